// ===== rtl/core/tsct_pkg.sv =====
// Shared types, constants and rounding helpers of the sine, cosine and tangent unit.
// No dependencies.
package tsct_pkg;

	localparam int TERMS_DEFAULT = 26;

	localparam int MAG_W    = 48;   // unsigned Q.40 magnitudes
	localparam int PROD_W   = 56;   // rounded product / quotient
	localparam int SUM_W    = 56;   // signed Q.40 series sum
	localparam int DIV_STEP = 8;    // quotient bits per cycle in the series divider
	localparam int DIV_CYC  = PROD_W / DIV_STEP;
	localparam int TAN_BITS = 32;

	localparam logic [63:0] PI_NUM = 64'd314159265359;
	localparam logic [63:0] PI_DEN = 64'd100000000000;
	localparam logic [63:0] PI_HI  = (PI_NUM << 20) / PI_DEN;
	localparam logic [63:0] PI_RM  = (PI_NUM << 20) % PI_DEN;
	localparam logic [63:0] PI_Q   = (PI_HI << 20) + (((PI_RM << 20) + PI_DEN / 2) / PI_DEN);
	localparam logic [MAG_W-1:0] TWO_PI_M  = MAG_W'(PI_Q << 1);
	localparam logic [MAG_W-1:0] HALF_PI_M = MAG_W'(PI_Q >> 1);

	typedef enum logic [1:0] {
		OP_SIN  = 2'd0,
		OP_COS  = 2'd1,
		OP_TAN  = 2'd2,
		OP_NONE = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ZERO_COS = 2'd1,
		ST_SAT      = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_REDUCE,
		S_SETUP,
		S_SQR_GO,
		S_SQR_WAIT,
		S_MUL_GO,
		S_MUL_WAIT,
		S_DIV,
		S_ACC,
		S_SER_END,
		S_TAN_CHK,
		S_TAN_DIV,
		S_TAN_FIN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic             start;
		logic [MAG_W-1:0] a;
		logic [MAG_W-1:0] b;
	} mul_req_t;

	// sign and magnitude to a saturated 32-bit word
	function automatic logic [31:0] pack_q24(input logic neg, input logic [40:0] mag);
		logic [40:0] m;
		m = mag;
		if (neg) begin
			if (m > 41'h0_8000_0000)
				m = 41'h0_8000_0000;
			return 32'(41'd0 - m);
		end
		if (m > 41'h0_7FFF_FFFF)
			m = 41'h0_7FFF_FFFF;
		return m[31:0];
	endfunction

	function automatic logic [31:0] to_q24(input logic signed [SUM_W-1:0] v);
		logic             neg;
		logic [SUM_W-1:0] mag;
		logic [SUM_W-1:0] rnd;
		neg = v[SUM_W-1];
		mag = neg ? SUM_W'(-v) : SUM_W'(v);
		rnd = (mag + SUM_W'(32768)) >> 16;
		return pack_q24(neg, rnd[40:0]);
	endfunction

endpackage

// ===== rtl/core/tsct_if.sv =====
// Request and response channel interfaces of the sine, cosine and tangent unit.
// Uses nothing from the package.
interface tsct_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         opcode;
	logic signed [31:0] angle;

	modport source(output valid, output opcode, output angle, input ready);
	modport sink(input valid, input opcode, input angle, output ready);
endinterface

interface tsct_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;
	logic [1:0]         status;

	modport source(output valid, output value, output status, input ready);
	modport sink(input valid, input value, input status, output ready);
endinterface

// ===== rtl/core/taylor_sine_cosine_tangent_top.sv =====
// Sine, cosine and tangent of a Q8.24 angle by Taylor series on one shared multiplier.
// Sine or cosine: angle reduction by multiples of 2*pi, setup, squaring of the argument, then
// per term a multiply by the square, a divide and an accumulate.
// Tangent: two series (sine, then cosine) plus a restoring divide of sine by cosine.
// One request at a time, next one taken in the cycle after the result loads; one may wait on it.
// Depends on tsct_pkg, tsct_if, tsct_qmul. Reset clears the sequencer and the result valid.
module taylor_sine_cosine_tangent_top #(
	parameter int TERMS = tsct_pkg::TERMS_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	tsct_req_if.sink      req,
	tsct_rsp_if.source    rsp
);
	import tsct_pkg::*;

	localparam int KW = $clog2(TERMS + 1);
	localparam int DW = $clog2(4 * TERMS * TERMS);

	state_t state_q, state_d;

	logic [1:0]              op_q;
	logic                    neg_q;
	logic                    pass_q;
	logic [MAG_W-1:0]        m_q;
	logic [2:0]              red_cnt_q;
	logic [MAG_W-1:0]        xmag_q;
	logic [MAG_W-1:0]        x2_q;
	logic [MAG_W-1:0]        term_q;
	logic                    tneg_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [SUM_W-1:0] sin_q;
	logic [KW-1:0]           k_q;
	logic [DW-1:0]           d_q;
	logic [PROD_W-1:0]       prod_q;
	logic [DW-1:0]           rem_q;
	logic [2:0]              dcnt_q;
	logic [MAG_W-1:0]        ms_q;
	logic [MAG_W-1:0]        mc_q;
	logic                    tan_neg_q;
	logic [MAG_W-1:0]        trem_q;
	logic [TAN_BITS-1:0]     tbits_q;
	logic [TAN_BITS-1:0]     tq_q;
	logic [5:0]              tcnt_q;
	logic [31:0]             res_val_q;
	logic [1:0]              res_st_q;
	logic                    rsp_valid_q;
	logic [31:0]             rsp_value_q;
	logic [1:0]              rsp_status_q;

	mul_req_t          mreq;
	logic              mul_done;
	logic [PROD_W-1:0] mul_prod;

	logic                    in_take;
	logic                    out_free;
	logic                    red_last;
	logic                    term_last;
	logic [MAG_W-1:0]        red_step;
	logic signed [MAG_W:0]   x_s;
	logic signed [SUM_W-1:0] ser_val;
	logic [PROD_W-1:0]       dp;
	logic [DW-1:0]           dr;
	logic [DW:0]             dt;
	logic [MAG_W:0]          tr2;
	logic [TAN_BITS:0]       tq_inc;
	logic [31:0]             tq_rnd;
	logic [31:0]             abs_angle;

	tsct_qmul u_qmul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	assign in_take   = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign red_last  = (red_cnt_q == 3'd0);
	assign term_last = (k_q == KW'(TERMS - 1));
	assign red_step  = TWO_PI_M << red_cnt_q;
	assign abs_angle = req.angle[31] ? 32'(-req.angle) : 32'(req.angle);

	always_comb begin
		if (pass_q)
			x_s = $signed({1'b0, HALF_PI_M}) - $signed({1'b0, m_q});
		else
			x_s = $signed({1'b0, m_q});
	end

	always_comb begin
		if (!pass_q && neg_q)
			ser_val = -sum_q;
		else
			ser_val = sum_q;
	end

	// series divider: DIV_STEP quotient bits per cycle, shifted into prod_q
	always_comb begin
		dr = rem_q;
		dp = prod_q;
		dt = '0;
		for (int i = 0; i < DIV_STEP; i++) begin
			dt = {dr, dp[PROD_W-1]};
			dp = dp << 1;
			if (dt >= {1'b0, d_q}) begin
				dt = dt - {1'b0, d_q};
				dp[0] = 1'b1;
			end
			dr = dt[DW-1:0];
		end
	end

	assign tr2    = {trem_q, tbits_q[TAN_BITS-1]};
	assign tq_inc = {1'b0, tq_q} + (TAN_BITS+1)'(1);
	assign tq_rnd = tq_inc[TAN_BITS:1];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_take)
					state_d = (req.opcode == OP_NONE) ? S_DONE : S_REDUCE;
			end
			S_REDUCE:   if (red_last) state_d = S_SETUP;
			S_SETUP:    state_d = S_SQR_GO;
			S_SQR_GO:   state_d = S_SQR_WAIT;
			S_SQR_WAIT: if (mul_done) state_d = S_MUL_GO;
			S_MUL_GO:   state_d = S_MUL_WAIT;
			S_MUL_WAIT: if (mul_done) state_d = S_DIV;
			S_DIV:      if (dcnt_q == 3'(DIV_CYC - 1)) state_d = S_ACC;
			S_ACC:      state_d = term_last ? S_SER_END : S_MUL_GO;
			S_SER_END: begin
				if (op_q == OP_TAN)
					state_d = pass_q ? S_TAN_CHK : S_SETUP;
				else
					state_d = S_DONE;
			end
			S_TAN_CHK: begin
				if (mc_q == '0 || {7'd0, ms_q} >= {mc_q, 7'd0})
					state_d = S_DONE;
				else
					state_d = S_TAN_DIV;
			end
			S_TAN_DIV:  if (tcnt_q == '0) state_d = S_TAN_FIN;
			S_TAN_FIN:  state_d = S_DONE;
			S_DONE:     if (out_free) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		req.ready  = (state_q == S_IDLE);
		mreq.start = (state_q == S_SQR_GO) || (state_q == S_MUL_GO);
		if (state_q == S_SQR_GO || state_q == S_SQR_WAIT) begin
			mreq.a = xmag_q;
			mreq.b = xmag_q;
		end else begin
			mreq.a = term_q;
			mreq.b = x2_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q      <= req.opcode;
				neg_q     <= req.angle[31];
				m_q       <= {abs_angle, 16'd0};
				red_cnt_q <= 3'd4;
				pass_q    <= (req.opcode == OP_COS);
				res_val_q <= '0;
				res_st_q  <= ST_OK;
			end
			S_REDUCE: begin
				if (m_q >= red_step)
					m_q <= m_q - red_step;
				red_cnt_q <= red_cnt_q - 3'd1;
			end
			S_SETUP: begin
				xmag_q <= x_s[MAG_W] ? MAG_W'(-x_s) : MAG_W'(x_s);
				term_q <= x_s[MAG_W] ? MAG_W'(-x_s) : MAG_W'(x_s);
				tneg_q <= x_s[MAG_W];
				sum_q  <= SUM_W'(x_s);
				k_q    <= KW'(1);
				d_q    <= DW'(6);
			end
			S_SQR_WAIT: begin
				if (mul_done)
					x2_q <= mul_prod[MAG_W-1:0];
			end
			S_MUL_WAIT: begin
				if (mul_done) begin
					prod_q <= mul_prod;
					rem_q  <= '0;
					dcnt_q <= '0;
				end
			end
			S_DIV: begin
				prod_q <= dp;
				rem_q  <= dr;
				dcnt_q <= dcnt_q + 3'd1;
			end
			S_ACC: begin
				term_q <= prod_q[MAG_W-1:0];
				tneg_q <= !tneg_q;
				if (tneg_q)
					sum_q <= sum_q + $signed(SUM_W'(prod_q[MAG_W-1:0]));
				else
					sum_q <= sum_q - $signed(SUM_W'(prod_q[MAG_W-1:0]));
				k_q <= k_q + KW'(1);
				d_q <= d_q + DW'({k_q, 3'b000}) + DW'(6);
			end
			S_SER_END: begin
				res_val_q <= to_q24(ser_val);
				res_st_q  <= ST_OK;
				if (op_q == OP_TAN) begin
					if (!pass_q) begin
						sin_q  <= ser_val;
						pass_q <= 1'b1;
					end else begin
						ms_q      <= sin_q[SUM_W-1] ? MAG_W'(-sin_q) : MAG_W'(sin_q);
						mc_q      <= sum_q[SUM_W-1] ? MAG_W'(-sum_q) : MAG_W'(sum_q);
						tan_neg_q <= sin_q[SUM_W-1] != sum_q[SUM_W-1];
					end
				end
			end
			S_TAN_CHK: begin
				if (mc_q == '0) begin
					res_val_q <= '0;
					res_st_q  <= ST_ZERO_COS;
				end else if ({7'd0, ms_q} >= {mc_q, 7'd0}) begin
					res_val_q <= tan_neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
					res_st_q  <= ST_SAT;
				end
				trem_q  <= ms_q >> 7;
				tbits_q <= {ms_q[6:0], 25'd0};
				tq_q    <= '0;
				tcnt_q  <= 6'(TAN_BITS - 1);
			end
			S_TAN_DIV: begin
				if (tr2 >= {1'b0, mc_q}) begin
					trem_q <= MAG_W'(tr2 - {1'b0, mc_q});
					tq_q   <= {tq_q[TAN_BITS-2:0], 1'b1};
				end else begin
					trem_q <= tr2[MAG_W-1:0];
					tq_q   <= {tq_q[TAN_BITS-2:0], 1'b0};
				end
				tbits_q <= tbits_q << 1;
				tcnt_q  <= tcnt_q - 6'd1;
			end
			S_TAN_FIN: begin
				if (tq_rnd > (tan_neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF)) begin
					res_val_q <= tan_neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
					res_st_q  <= ST_SAT;
				end else begin
					res_val_q <= pack_q24(tan_neg_q, 41'(tq_rnd));
					res_st_q  <= ST_OK;
				end
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			rsp_value_q  <= res_val_q;
			rsp_status_q <= res_st_q;
		end
	end

	assign rsp.valid  = rsp_valid_q;
	assign rsp.value  = rsp_value_q;
	assign rsp.status = rsp_status_q;

	a_zero_cos_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == ST_ZERO_COS |-> rsp.value == 32'd0)
		else $error("zero-cosine result carries a nonzero value");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == ST_SAT |->
		rsp.value == 32'h7FFF_FFFF || rsp.value == 32'h8000_0000)
		else $error("saturated result is not an extreme value");

	a_mul_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> state_q == S_SQR_WAIT || state_q == S_MUL_WAIT)
		else $error("multiplier finished outside a wait state");

	a_no_fast_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> !$rose(rsp.valid))
		else $error("result appeared one cycle after a transfer");
endmodule

// ===== rtl/core/tsct_qmul.sv =====
// Shared Q.40 magnitude multiplier: four 32x32 partial products, rounded result.
// Depends on tsct_pkg.
module tsct_qmul (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tsct_pkg::mul_req_t           req,
	output logic                         done,
	output logic [tsct_pkg::PROD_W-1:0]  prod
);
	import tsct_pkg::*;

	logic        busy_q;
	logic [2:0]  cnt_q;
	logic [1:0]  sh_s1;
	logic [63:0] mp_s1;
	logic [95:0] acc_q;
	logic        done_q;
	logic [PROD_W-1:0] prod_q;
	logic [31:0] op_a;
	logic [31:0] op_b;
	logic [95:0] addend;
	logic [95:0] rounded;

	always_comb begin
		case (cnt_q[1:0])
			2'd0: begin
				op_a = req.a[31:0];
				op_b = req.b[31:0];
			end
			2'd1: begin
				op_a = req.a[31:0];
				op_b = 32'(req.b[MAG_W-1:32]);
			end
			2'd2: begin
				op_a = 32'(req.a[MAG_W-1:32]);
				op_b = req.b[31:0];
			end
			default: begin
				op_a = 32'(req.a[MAG_W-1:32]);
				op_b = 32'(req.b[MAG_W-1:32]);
			end
		endcase
	end

	always_comb begin
		case (sh_s1)
			2'd0:    addend = 96'(mp_s1);
			2'd3:    addend = {mp_s1[31:0], 64'd0};
			default: addend = {mp_s1, 32'd0};
		endcase
	end

	assign rounded = acc_q + 96'(64'h80_0000_0000);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd5) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q < 3'd4) begin
				mp_s1 <= 64'(op_a) * 64'(op_b);
				sh_s1 <= cnt_q[1:0];
			end
			if (cnt_q >= 3'd1 && cnt_q <= 3'd4)
				acc_q <= acc_q + addend;
			if (cnt_q == 3'd5)
				prod_q <= rounded[40 +: PROD_W];
		end
	end

	assign done = done_q;
	assign prod = prod_q;
endmodule
